// File: hw/rtl/cet_pkg.sv
// cet_pkg: shared constants, codes and the controller-to-datapath command type
// for the coulombic-efficiency trim block; no dependencies
`timescale 1ns / 1ps

package cet_pkg;

   // fixed point and default sizing
   localparam int     FRAC_BITS        = 16;
   localparam int     ACC_WIDTH_DEF    = 48;
   localparam longint RATED_CHARGE_DEF = 64'sd92160000000;

   // request opcodes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_ADJUST = 2'd1;
   localparam logic [1:0] OP_RESET  = 2'd2;

   // csr register indexes
   localparam int         CSR_IDX_W      = 3;
   localparam int         CSR_DATA_W     = 32;
   localparam logic [2:0] CSR_EFFICIENCY = 3'd0;
   localparam logic [2:0] CSR_LOOP_GAIN  = 3'd1;
   localparam logic [2:0] CSR_STEP_LIMIT = 3'd2;
   localparam logic [2:0] CSR_BOUND_SPAN = 3'd3;
   localparam logic [2:0] CSR_HOLD_TIME  = 3'd4;

   // csr reset values
   localparam logic [16:0] EFFICIENCY_RST = 17'd65438;
   localparam logic [16:0] LOOP_GAIN_RST  = 17'd32768;
   localparam logic [15:0] STEP_LIMIT_RST = 16'd1311;
   localparam logic [15:0] BOUND_SPAN_RST = 16'd3277;
   localparam logic [31:0] HOLD_TIME_RST  = 32'd0;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture request, set up divider
      logic mul;       // current*interval and efficiency*scalar
      logic prod;      // weighted charge product
      logic div_step;  // one restoring divide step
      logic gain;      // gain times (ratio - one)
      logic sadd;      // soft-landed ratio
      logic scale;     // scalar times soft ratio
      logic step;      // per-adjust step clamp
      logic commit;    // update state and load result
   } cmd_type;

endpackage

// File: hw/rtl/coulomb_efficiency_trim_top.sv
// coulomb_efficiency_trim_top: top level of the coulombic-efficiency trim block
// sequence: sample runs mul, prod, fin; reset item goes straight to fin; adjust runs
// the restoring divider (one quotient bit per cycle), then gain, sadd, scale, step, fin
// throughput: one request at a time; the next request is taken once the
// previous one has written the result register, even while that result waits
// reset: synchronous active high; totals go to minus/plus rated charge
// Depends on cet_pkg, cet_ctrl, cet_dpath
`timescale 1ns / 1ps

module coulomb_efficiency_trim_top #(
   parameter int     ACC_WIDTH    = cet_pkg::ACC_WIDTH_DEF,
   parameter longint RATED_CHARGE = cet_pkg::RATED_CHARGE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_opcode,
   input  logic signed [23:0]             req_current,
   input  logic [15:0]                    req_interval_ms,
   input  logic                           req_saturated_in,
   input  logic [31:0]                    req_time_now_ms,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_desat_event,
   output logic                           rsp_applied,
   output logic [17:0]                    rsp_scalar_out,
   output logic signed [47:0]             rsp_charge_total,
   output logic signed [47:0]             rsp_discharge_total,
   // csr write channel, always ready
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cet_pkg::CSR_DATA_W-1:0] csr_data
);

   // commands from the sequencer into the datapath
   cet_pkg::cmd_type cmd;

   // csr writes land directly in the datapath registers
   assign csr_ready = 1'b1;

   // controller: one-hot sequencer, divide counter, result valid
   cet_ctrl #(
      .ITER (ACC_WIDTH + cet_pkg::FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // datapath: totals, scalar, multipliers, divider, result registers
   cet_dpath #(
      .ACC_WIDTH    (ACC_WIDTH),
      .RATED_CHARGE (RATED_CHARGE)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_opcode          (req_opcode),
      .req_current         (req_current),
      .req_interval_ms     (req_interval_ms),
      .req_saturated_in    (req_saturated_in),
      .req_time_now_ms     (req_time_now_ms),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_desat_event     (rsp_desat_event),
      .rsp_applied         (rsp_applied),
      .rsp_scalar_out      (rsp_scalar_out),
      .rsp_charge_total    (rsp_charge_total),
      .rsp_discharge_total (rsp_discharge_total)
   );

endmodule

// File: hw/rtl/cet_ctrl.sv
// cet_ctrl: sequencing state machine and result valid for the trim block
// depends on cet_pkg
`timescale 1ns / 1ps

module cet_ctrl #(
   parameter int ITER = cet_pkg::ACC_WIDTH_DEF + cet_pkg::FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_opcode,
   output logic             req_stall,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output cet_pkg::cmd_type cmd
);

   localparam int CW = $clog2(ITER);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MUL   = 9'b000000010,
      S_PROD  = 9'b000000100,
      S_DIV   = 9'b000001000,
      S_GAIN  = 9'b000010000,
      S_SADD  = 9'b000100000,
      S_SCALE = 9'b001000000,
      S_STEP  = 9'b010000000,
      S_FIN   = 9'b100000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CW'(ITER - 1);
               if (req_opcode == cet_pkg::OP_SAMPLE) begin
                  state_in = S_MUL;
               end else if (req_opcode == cet_pkg::OP_ADJUST) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_FIN;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.gain = 1'b1;
            state_in = S_SADD;
         end
         S_SADD: begin
            cmd.sadd = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start work");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == '0) |=> (state_ff == S_GAIN))
      else $error("divider did not hand over after last step");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

endmodule

// File: hw/rtl/cet_dpath.sv
// cet_dpath: csr registers, totals, trim scalar, multipliers, serial divider
// and result registers; depends on cet_pkg
`timescale 1ns / 1ps

module cet_dpath #(
   parameter int     ACC_WIDTH    = cet_pkg::ACC_WIDTH_DEF,
   parameter longint RATED_CHARGE = cet_pkg::RATED_CHARGE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cet_pkg::cmd_type               cmd,
   input  logic [1:0]                     req_opcode,
   input  logic signed [23:0]             req_current,
   input  logic [15:0]                    req_interval_ms,
   input  logic                           req_saturated_in,
   input  logic [31:0]                    req_time_now_ms,
   input  logic                           csr_valid,
   input  logic [cet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cet_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                           rsp_desat_event,
   output logic                           rsp_applied,
   output logic [17:0]                    rsp_scalar_out,
   output logic signed [47:0]             rsp_charge_total,
   output logic signed [47:0]             rsp_discharge_total
);

   localparam int F   = cet_pkg::FRAC_BITS;
   localparam int ONE = 1 << F;
   localparam int QW  = ACC_WIDTH + F;
   localparam int SW  = ((ACC_WIDTH > 43) ? ACC_WIDTH : 43) + 1;

   localparam logic signed [64:0] AMAX_L  = (65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1;
   localparam logic signed [64:0] RC_L    = 65'(RATED_CHARGE);
   localparam logic signed [64:0] RST_D_L = (RC_L > AMAX_L) ? AMAX_L : RC_L;
   localparam logic signed [64:0] RST_C_L = (RC_L > AMAX_L + 65'sd1) ?
                                            -(AMAX_L + 65'sd1) : -RC_L;
   localparam logic signed [SW-1:0] AMAX_S = SW'(AMAX_L);
   localparam logic signed [SW-1:0] AMIN_S = -AMAX_S - SW'(1);
   localparam logic [40:0]          RATIO_CAP = 41'h1 << 40;

   // csr
   logic [16:0] eff_ff, gain_ff;
   logic [15:0] step_ff, span_ff;
   logic [31:0] hold_ff;

   // architectural state
   logic signed [ACC_WIDTH-1:0] chg_ff, chg_in, dis_ff, dis_in;
   logic [17:0]                 scalar_ff, scalar_in;
   logic                        sat_seen_ff, sat_seen_in;
   logic [31:0]                 last_ff, last_in;

   // captured request
   logic [1:0]         op_ff;
   logic signed [23:0] cur_ff;
   logic [15:0]        dt_ff;
   logic               satin_ff;
   logic [31:0]        now_ff;
   logic               ok_ff;

   // sample path
   logic signed [39:0] p_ff;
   logic [18:0]        e_ff;
   logic [41:0]        pe_ff;
   logic [34:0]        e_mul;
   logic [57:0]        pe_mul;

   // divider
   logic [ACC_WIDTH-1:0] rem_ff, den_ff, num;
   logic [QW-1:0]        dvd_ff;
   logic [ACC_WIDTH:0]   div_t, div_sub;
   logic                 div_ge;

   // adjust path
   logic [40:0]        ratio;
   logic signed [41:0] rm1;
   logic signed [59:0] gp_ff;
   logic signed [43:0] s_ff;
   logic signed [62:0] np_ff;
   logic signed [46:0] n_val, hi1, lo1, n_a, n_b;
   logic signed [19:0] n1_ff, hi2, lo2, n_c, n_d;

   // commit logic
   logic                    cur_pos, fire, applied;
   logic signed [SW-1:0]    addend, acc_sel, acc_sum, acc_clamp;
   logic [31:0]             elapsed;

   assign num     = ACC_WIDTH'(0) - dis_ff;
   assign e_mul   = eff_ff * scalar_ff;
   assign pe_mul  = p_ff[38:0] * e_ff;
   assign div_t   = {rem_ff, dvd_ff[QW-1]};
   assign div_sub = div_t - {1'b0, den_ff};
   assign div_ge  = div_t >= {1'b0, den_ff};

   assign ratio = (dvd_ff > QW'(RATIO_CAP)) ? RATIO_CAP : dvd_ff[40:0];
   assign rm1   = $signed({1'b0, ratio}) - $signed(42'(ONE));
   assign n_val = np_ff[62:F];
   assign hi1   = $signed(47'(scalar_ff)) + $signed(47'(step_ff));
   assign lo1   = $signed(47'(scalar_ff)) - $signed(47'(step_ff));
   assign n_a   = (n_val < hi1) ? n_val : hi1;
   assign n_b   = (n_a > lo1) ? n_a : lo1;
   assign hi2   = $signed(20'(ONE)) + $signed(20'(span_ff));
   assign lo2   = $signed(20'(ONE)) - $signed(20'(span_ff));
   assign n_c   = (n1_ff < hi2) ? n1_ff : hi2;
   assign n_d   = (n_c > lo2) ? n_c : lo2;

   assign cur_pos   = !cur_ff[23] && (cur_ff != '0);
   assign addend    = cur_pos ? $signed(SW'(pe_ff)) : SW'(p_ff);
   assign acc_sel   = cur_pos ? SW'(chg_ff) : SW'(dis_ff);
   assign acc_sum   = acc_sel + addend;
   assign acc_clamp = (acc_sum > AMAX_S) ? AMAX_S : ((acc_sum < AMIN_S) ? AMIN_S : acc_sum);
   assign elapsed   = now_ff - last_ff;
   assign fire      = (op_ff == cet_pkg::OP_SAMPLE) && sat_seen_ff && !satin_ff &&
                      (elapsed > hold_ff);
   assign applied   = (op_ff == cet_pkg::OP_ADJUST) && ok_ff;

   always_comb begin
      chg_in      = chg_ff;
      dis_in      = dis_ff;
      scalar_in   = scalar_ff;
      sat_seen_in = sat_seen_ff;
      last_in     = last_ff;
      case (op_ff)
         cet_pkg::OP_SAMPLE: begin
            if (cur_pos) begin
               chg_in = ACC_WIDTH'(acc_clamp);
            end else begin
               dis_in = ACC_WIDTH'(acc_clamp);
            end
            if (sat_seen_ff) begin
               if (fire) begin
                  sat_seen_in = 1'b0;
                  last_in     = now_ff;
               end
            end else if (satin_ff) begin
               sat_seen_in = 1'b1;
            end
         end
         cet_pkg::OP_ADJUST: begin
            if (ok_ff) begin
               scalar_in = n_d[17:0];
            end
            chg_in = '0;
            dis_in = '0;
         end
         cet_pkg::OP_RESET: begin
            chg_in      = '0;
            dis_in      = '0;
            sat_seen_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // csr and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff      <= cet_pkg::EFFICIENCY_RST;
         gain_ff     <= cet_pkg::LOOP_GAIN_RST;
         step_ff     <= cet_pkg::STEP_LIMIT_RST;
         span_ff     <= cet_pkg::BOUND_SPAN_RST;
         hold_ff     <= cet_pkg::HOLD_TIME_RST;
         chg_ff      <= ACC_WIDTH'(RST_C_L);
         dis_ff      <= ACC_WIDTH'(RST_D_L);
         scalar_ff   <= 18'(ONE);
         sat_seen_ff <= 1'b0;
         last_ff     <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               cet_pkg::CSR_EFFICIENCY: eff_ff  <= csr_data[16:0];
               cet_pkg::CSR_LOOP_GAIN:  gain_ff <= csr_data[16:0];
               cet_pkg::CSR_STEP_LIMIT: step_ff <= csr_data[15:0];
               cet_pkg::CSR_BOUND_SPAN: span_ff <= csr_data[15:0];
               cet_pkg::CSR_HOLD_TIME:  hold_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            chg_ff      <= chg_in;
            dis_ff      <= dis_in;
            scalar_ff   <= scalar_in;
            sat_seen_ff <= sat_seen_in;
            last_ff     <= last_in;
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         cur_ff   <= req_current;
         dt_ff    <= req_interval_ms;
         satin_ff <= req_saturated_in;
         now_ff   <= req_time_now_ms;
         ok_ff    <= (chg_ff > 0) && (dis_ff <= 0);
         rem_ff   <= '0;
         den_ff   <= chg_ff;
         dvd_ff   <= QW'(num) << F;
      end
      if (cmd.mul) begin
         p_ff <= cur_ff * $signed({1'b0, dt_ff});
         e_ff <= e_mul[34:F];
      end
      if (cmd.prod) begin
         pe_ff <= pe_mul[57:F];
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? div_sub[ACC_WIDTH-1:0] : div_t[ACC_WIDTH-1:0];
         dvd_ff <= {dvd_ff[QW-2:0], div_ge};
      end
      if (cmd.gain) begin
         gp_ff <= $signed({1'b0, gain_ff}) * rm1;
      end
      if (cmd.sadd) begin
         s_ff <= $signed(gp_ff[59:F]) + $signed(44'(ONE));
      end
      if (cmd.scale) begin
         np_ff <= $signed({1'b0, scalar_ff}) * s_ff;
      end
      if (cmd.step) begin
         n1_ff <= n_b[19:0];
      end
      if (cmd.commit) begin
         rsp_desat_event     <= fire;
         rsp_applied         <= applied;
         rsp_scalar_out      <= scalar_in;
         rsp_charge_total    <= 48'(chg_in);
         rsp_discharge_total <= 48'(dis_in);
      end
   end

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for coulomb_efficiency_trim_top; a directed table
// and random sequences are checked against an in-bench trim predictor
// Depends on cet_pkg and coulomb_efficiency_trim_top
`timescale 1ns / 1ps

module tb_top;

   localparam longint ONE_Q    = 64'sd1 << cet_pkg::FRAC_BITS;
   localparam longint TOT_MAX  = (64'sd1 <<< 47) - 1;
   localparam longint TOT_MIN  = -(64'sd1 <<< 47);
   localparam logic [1:0] OP_UNDEF = 2'd3;   // unused code, must change nothing
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [23:0] current;
      logic [15:0]        interval_ms;
      logic               saturated_in;
      logic [31:0]        time_now_ms;
   } trim_req_type;

   typedef struct packed {
      logic               desat_event;
      logic               applied;
      logic [17:0]        scalar_out;
      logic signed [47:0] charge_total;
      logic signed [47:0] discharge_total;
   } trim_rsp_type;

   typedef struct {
      trim_req_type rq;
      bit           typed;   // expected result written in by hand
      trim_rsp_type res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = cet_pkg::OP_SAMPLE;
   logic signed [23:0] req_current = '0;
   logic [15:0] req_interval_ms = '0;
   logic req_saturated_in = 1'b0;
   logic [31:0] req_time_now_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_desat_event, rsp_applied;
   logic [17:0] rsp_scalar_out;
   logic signed [47:0] rsp_charge_total, rsp_discharge_total;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cet_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cet_pkg::CSR_DATA_W-1:0] csr_data = '0;

   coulomb_efficiency_trim_top u_top (.*);

   // 250 MHz bench clock
   initial begin
      forever #2 clock = ~clock;
   end

   // predictor copy of the block's registers and state
   longint eff_q, gain_q, step_q, span_q;
   logic [31:0] hold_ms;
   longint charge_sum, discharge_sum, scalar_q;
   bit sat_flag;
   logic [31:0] last_desat;

   trim_rsp_type expected_rsps[$];
   int errors = 0;
   bit long_hold = 1'b0;   // receiver holds off for a long stretch
   bit quiet = 1'b0;       // no random idling on either side
   logic [31:0] clock_ms = '0;   // running time for random samples

   function automatic longint clamp_total(longint v);
      if (v > TOT_MAX) return TOT_MAX;
      if (v < TOT_MIN) return TOT_MIN;
      return v;
   endfunction

   // advances the predicted state by one request and returns its result
   function automatic trim_rsp_type predict_trim(trim_req_type rq);
      trim_rsp_type r;
      longint cur, p, e, rat, damped, nxt;
      logic [63:0] num;
      cur = rq.current;
      r = '0;
      case (rq.opcode)
         cet_pkg::OP_SAMPLE: begin
            p = cur * longint'(rq.interval_ms);
            if (cur > 0) begin
               e = (eff_q * scalar_q) >> cet_pkg::FRAC_BITS;
               p = (p * e) >> cet_pkg::FRAC_BITS;
               charge_sum = clamp_total(charge_sum + p);
            end else begin
               discharge_sum = clamp_total(discharge_sum + p);
            end
            if (sat_flag) begin
               if (!rq.saturated_in && (rq.time_now_ms - last_desat) > hold_ms) begin
                  r.desat_event = 1'b1;
                  sat_flag = 1'b0;
                  last_desat = rq.time_now_ms;
               end
            end else if (rq.saturated_in) begin
               sat_flag = 1'b1;
            end
         end
         cet_pkg::OP_ADJUST: begin
            if (charge_sum > 0 && discharge_sum <= 0) begin
               num = -discharge_sum;
               // ratio in Q16, capped at 2^40 when the integer part is too big
               if (num / charge_sum >= (64'd1 << 24)) rat = 64'sd1 <<< 40;
               else rat = (num << cet_pkg::FRAC_BITS) / charge_sum;
               damped = ((gain_q * (rat - ONE_Q)) >>> cet_pkg::FRAC_BITS) + ONE_Q;
               nxt = (scalar_q * damped) >>> cet_pkg::FRAC_BITS;
               if (nxt > scalar_q + step_q) nxt = scalar_q + step_q;
               if (nxt < scalar_q - step_q) nxt = scalar_q - step_q;
               if (nxt > ONE_Q + span_q) nxt = ONE_Q + span_q;
               if (nxt < ONE_Q - span_q) nxt = ONE_Q - span_q;
               scalar_q = nxt;
               r.applied = 1'b1;
            end
            charge_sum = 0;
            discharge_sum = 0;
         end
         cet_pkg::OP_RESET: begin
            charge_sum = 0;
            discharge_sum = 0;
            sat_flag = 1'b0;
         end
         default: ;
      endcase
      r.scalar_out = scalar_q[17:0];
      r.charge_total = charge_sum[47:0];
      r.discharge_total = discharge_sum[47:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      trim_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_desat_event !== want.desat_event)
               report_mismatch("desat_event", rsp_desat_event, want.desat_event);
            if (rsp_applied !== want.applied)
               report_mismatch("applied", rsp_applied, want.applied);
            if (rsp_scalar_out !== want.scalar_out)
               report_mismatch("scalar_out", rsp_scalar_out, want.scalar_out);
            if (rsp_charge_total !== want.charge_total)
               report_mismatch("charge_total", rsp_charge_total, want.charge_total);
            if (rsp_discharge_total !== want.discharge_total)
               report_mismatch("discharge_total", rsp_discharge_total,
                               want.discharge_total);
         end
      end
   end

   // receiver stalls: short gaps mostly, a few long ones, and the long hold
   initial begin
      int len;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // offer one request and hold it until taken; predict on acceptance
   task automatic send_request(trim_req_type rq, bit typed, trim_rsp_type typed_rsp);
      trim_rsp_type pred;
      req_valid <= 1'b1;
      req_opcode <= rq.opcode;
      req_current <= rq.current;
      req_interval_ms <= rq.interval_ms;
      req_saturated_in <= rq.saturated_in;
      req_time_now_ms <= rq.time_now_ms;
      do @(posedge clock); while (req_stall);
      pred = predict_trim(rq);
      expected_rsps.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic sender_gap();
      int len;
      if (quiet || $urandom_range(0, 2) != 0) return;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      req_valid <= 1'b0;
      repeat (len) @(posedge clock);
   endtask

   // sender pauses until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic [cet_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         cet_pkg::CSR_EFFICIENCY: eff_q = val[16:0];
         cet_pkg::CSR_LOOP_GAIN:  gain_q = val[16:0];
         cet_pkg::CSR_STEP_LIMIT: step_q = val[15:0];
         cet_pkg::CSR_BOUND_SPAN: span_q = val[15:0];
         cet_pkg::CSR_HOLD_TIME:  hold_ms = val;
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [31:0] eff, logic [31:0] gain, logic [31:0] stp,
                           logic [31:0] span, logic [31:0] hold);
      csr_write(cet_pkg::CSR_EFFICIENCY, eff);
      csr_write(cet_pkg::CSR_LOOP_GAIN, gain);
      csr_write(cet_pkg::CSR_STEP_LIMIT, stp);
      csr_write(cet_pkg::CSR_BOUND_SPAN, span);
      csr_write(cet_pkg::CSR_HOLD_TIME, hold);
   endtask

   function automatic trim_req_type make_req(logic [1:0] op, logic signed [23:0] cur,
                                             logic [15:0] dt, logic sat, logic [31:0] now);
      trim_req_type rq;
      rq.opcode = op;
      rq.current = cur;
      rq.interval_ms = dt;
      rq.saturated_in = sat;
      rq.time_now_ms = now;
      return rq;
   endfunction

   // random sample: mostly realistic currents, sometimes full range bits
   function automatic trim_req_type rand_sample(bit big);
      logic signed [23:0] cur;
      logic [15:0] dt;
      logic [31:0] now;
      if (big) begin
         cur = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         dt = 16'hffff;
      end else begin
         case ($urandom_range(0, 3))
            0: cur = 24'($urandom);
            1: cur = 24'($urandom_range(0, 4000));
            default: cur = -$signed({1'b0, 23'($urandom_range(0, 5000))});
         endcase
         dt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1000));
      end
      clock_ms = clock_ms + $urandom_range(0, 700);
      now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
      return make_req(cet_pkg::OP_SAMPLE, cur, dt, $urandom_range(0, 2) == 0, now);
   endfunction

   // random request with a given opcode and noise in every other field
   function automatic trim_req_type rand_op(logic [1:0] op);
      return make_req(op, 24'($urandom), 16'($urandom), 1'($urandom), $urandom);
   endfunction

   // well-formed runs of samples closed by an adjust, with some noise mixed in
   task automatic run_random(int count, bit big);
      trim_rsp_type none;
      int k;
      none = '0;
      while (count > 0) begin
         k = big ? 1 : $urandom_range(1, 12);
         repeat (k) begin
            send_request(rand_sample(big), 1'b0, none);
            sender_gap();
            count--;
         end
         if (!big || $urandom_range(0, 60) == 0) begin
            case ($urandom_range(0, 19))
               0: send_request(rand_op(cet_pkg::OP_RESET), 1'b0, none);
               1: send_request(rand_op(OP_UNDEF), 1'b0, none);
               default: send_request(rand_op(cet_pkg::OP_ADJUST), 1'b0, none);
            endcase
            sender_gap();
            count--;
         end
      end
   endtask

   dir_row_type dir_rows[$];

   task automatic add_row(logic [1:0] op, logic signed [23:0] cur, logic [15:0] dt,
                          logic sat, logic [31:0] now, bit typed, trim_rsp_type res);
      dir_row_type row;
      row.rq = make_req(op, cur, dt, sat, now);
      row.typed = typed;
      row.res = res;
      dir_rows.push_back(row);
   endtask

   initial begin
      trim_rsp_type x;
      x = '0;
      // state after reset
      eff_q = cet_pkg::EFFICIENCY_RST; gain_q = cet_pkg::LOOP_GAIN_RST;
      step_q = cet_pkg::STEP_LIMIT_RST; span_q = cet_pkg::BOUND_SPAN_RST;
      hold_ms = cet_pkg::HOLD_TIME_RST;
      charge_sum = -cet_pkg::RATED_CHARGE_DEF; discharge_sum = cet_pkg::RATED_CHARGE_DEF;
      scalar_q = ONE_Q; sat_flag = 1'b0; last_desat = '0;

      // undefined opcode right after reset leaves the rated totals in place
      add_row(OP_UNDEF, 24'sh7fffff, 16'hffff, 1'b1, 32'hffffffff, 1'b1,
              {1'b0, 1'b0, 18'd65536, -48'sd92160000000, 48'sd92160000000});
      // adjust with negative charge: not applied, totals cleared
      add_row(cet_pkg::OP_ADJUST, 24'sd0, 16'd0, 1'b0, 32'd0, 1'b1,
              {1'b0, 1'b0, 18'd65536, 48'sd0, 48'sd0});
      add_row(cet_pkg::OP_RESET, 24'sd0, 16'd0, 1'b0, 32'd0, 1'b1,
              {1'b0, 1'b0, 18'd65536, 48'sd0, 48'sd0});
      // most negative current over the longest interval
      add_row(cet_pkg::OP_SAMPLE, 24'sh800000, 16'hffff, 1'b0, 32'd0, 1'b1,
              {1'b0, 1'b0, 18'd65536, 48'sd0, -48'sd549747425280});
      add_row(cet_pkg::OP_SAMPLE, 24'sh7fffff, 16'hffff, 1'b1, 32'd100, 1'b0, x);
      // desaturation across the time wrap
      add_row(cet_pkg::OP_SAMPLE, 24'sd0, 16'd0, 1'b0, 32'hffffffff, 1'b0, x);
      add_row(cet_pkg::OP_ADJUST, 24'sd0, 16'd0, 1'b0, 32'd0, 1'b0, x);
      add_row(cet_pkg::OP_SAMPLE, -24'sd1, 16'd1, 1'b1, 32'd5, 1'b0, x);
      add_row(cet_pkg::OP_SAMPLE, 24'sd1, 16'd1, 1'b1, 32'd5, 1'b0, x);
      add_row(cet_pkg::OP_SAMPLE, 24'sd1, 16'd3, 1'b0, 32'd5, 1'b0, x);
      // reset item clears a pending saturation
      add_row(cet_pkg::OP_SAMPLE, 24'sd0, 16'd7, 1'b1, 32'd9, 1'b0, x);
      add_row(cet_pkg::OP_RESET, 24'sd0, 16'd0, 1'b0, 32'd9, 1'b0, x);
      add_row(cet_pkg::OP_SAMPLE, 24'sd0, 16'd7, 1'b0, 32'd20, 1'b0, x);
      // zero charge: adjust not applied
      add_row(cet_pkg::OP_ADJUST, 24'sd0, 16'd0, 1'b0, 32'd0, 1'b0, x);
      // only charge, no discharge: ratio zero, step clamp pulls down
      add_row(cet_pkg::OP_SAMPLE, 24'sd3000, 16'd500, 1'b0, 32'd30, 1'b0, x);
      add_row(cet_pkg::OP_ADJUST, 24'sd0, 16'd0, 1'b0, 32'd0, 1'b0, x);
      // tiny charge, huge discharge: ratio hits its cap
      add_row(cet_pkg::OP_SAMPLE, 24'sd1, 16'd2, 1'b0, 32'd40, 1'b0, x);
      add_row(cet_pkg::OP_SAMPLE, 24'sh800000, 16'hffff, 1'b0, 32'd41, 1'b0, x);
      add_row(cet_pkg::OP_ADJUST, 24'sd0, 16'd0, 1'b0, 32'd0, 1'b0, x);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);
         sender_gap();
      end
      drain();

      // default registers, random sequences
      run_random(250, 1'b0);
      drain();

      // upper extremes; receiver holds off while the sender keeps offering
      set_regs(32'd65536, 32'd65536, 32'd65535, 32'd65535, 32'hffffffff);
      quiet = 1'b1;
      long_hold = 1'b1;
      run_random(40, 1'b0);
      quiet = 1'b0;
      run_random(110, 1'b0);
      drain();

      // lower extremes
      set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      run_random(150, 1'b0);
      drain();

      // totals driven into saturation at both ends
      set_regs(32'd65536, 32'd40000, 32'd3000, 32'd8000, 32'd200);
      run_random(420, 1'b1);
      drain();

      // random register values
      set_regs($urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 3000));
      run_random(180, 1'b0);
      drain();

      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
